// ----- sv/text_line_number_and_escape_filter_macros.svh -----
`ifndef TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_MACROS_SVH
`define TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TLF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TLF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- sv/tlf_pkg.sv -----
`timescale 1ns / 1ps

package tlf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_MODE      = 3'd0,
    REG_SQUEEZE_BLANK    = 3'd1,
    REG_SHOW_ENDS        = 3'd2,
    REG_SHOW_TABS        = 3'd3,
    REG_SHOW_NONPRINTING = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    NUM_OFF      = 2'd0,
    NUM_ALL      = 2'd1,
    NUM_NONBLANK = 2'd2,
    NUM_UNUSED   = 2'd3
  } number_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_TAB,
    ST_DOLLAR,
    ST_BODY
  } back_state_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_OFS  = 8'd64;
  localparam logic [7:0] HIGH_OFS  = 8'd128;

  // one classified item as handed from front to back
  typedef struct packed {
    logic             has_num;
    logic             has_dollar;
    logic [1:0]       body_last;
    logic [3:0][7:0]  body;
  } job_t;

endpackage

// ----- sv/tlf_front.sv -----
`timescale 1ns / 1ps

module tlf_front #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          file_start,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output tlf_pkg::job_t                 q_job,
  output logic [4*NUMBER_DIGITS-1:0]    q_digits
);
  import tlf_pkg::*;

  localparam int CW = 4 * NUMBER_DIGITS;

  number_mode_t     number_mode;
  logic             squeeze_blank;
  logic             show_ends;
  logic             show_tabs;
  logic             show_nonprinting;

  logic [CW-1:0]    count;
  logic             prev_nl;
  logic [1:0]       blank_run;

  logic             accept;
  logic             eff_prev;
  logic [CW-1:0]    eff_count;
  logic [1:0]       eff_blank;
  logic             is_nl;
  logic [1:0]       blank_next;
  logic             squeezed;
  logic             numbered;
  logic             all_nine;
  logic             carry;
  logic [CW-1:0]    bumped;
  logic [CW-1:0]    count_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode      <= NUM_OFF;
      squeeze_blank    <= 1'b0;
      show_ends        <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUMBER_MODE:      number_mode      <= number_mode_t'(cfg_data[1:0]);
        REG_SQUEEZE_BLANK:    squeeze_blank    <= cfg_data[0];
        REG_SHOW_ENDS:        show_ends        <= cfg_data[0];
        REG_SHOW_TABS:        show_tabs        <= cfg_data[0];
        REG_SHOW_NONPRINTING: show_nonprinting <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_prev  = file_start || prev_nl;
    eff_count = file_start ? '0 : count;
    eff_blank = file_start ? 2'd0 : blank_run;
    is_nl     = (in_byte == CH_NL);

    if (is_nl && eff_prev) begin
      blank_next = (eff_blank == 2'd3) ? 2'd3 : eff_blank + 2'd1;
    end else begin
      blank_next = 2'd0;
    end
    squeezed = squeeze_blank && (blank_next > 2'd1);
    numbered = eff_prev && ((number_mode == NUM_ALL) ||
                            (number_mode == NUM_NONBLANK && !is_nl));

    // decimal increment, least significant digit in the low nibble
    all_nine = 1'b1;
    carry    = 1'b1;
    bumped   = eff_count;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (eff_count[4*i +: 4] != 4'd9) all_nine = 1'b0;
      if (carry) begin
        if (eff_count[4*i +: 4] >= 4'd9) begin
          bumped[4*i +: 4] = 4'd0;
        end else begin
          bumped[4*i +: 4] = eff_count[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    // saturate at all nines
    if (all_nine) bumped = eff_count;
    count_next = (numbered && !squeezed) ? bumped : eff_count;

    q_job            = '0;
    q_job.has_num    = numbered;
    q_job.has_dollar = show_ends && is_nl;
    q_job.body[0]    = in_byte;
    q_job.body_last  = 2'd0;
    if (show_tabs && in_byte == CH_TAB) begin
      q_job.body[0]   = CH_CARET;
      q_job.body[1]   = CH_I;
      q_job.body_last = 2'd1;
    end else if (show_nonprinting &&
                 (in_byte <= 8'd8 || (in_byte >= 8'd11 && in_byte <= 8'd31))) begin
      q_job.body[0]   = CH_CARET;
      q_job.body[1]   = in_byte + CTRL_OFS;
      q_job.body_last = 2'd1;
    end else if (show_nonprinting && in_byte == CH_DEL) begin
      q_job.body[0]   = CH_CARET;
      q_job.body[1]   = CH_QUEST;
      q_job.body_last = 2'd1;
    end else if (show_nonprinting && in_byte >= 8'd128 && in_byte <= 8'd159) begin
      q_job.body[0]   = CH_M;
      q_job.body[1]   = CH_DASH;
      q_job.body[2]   = CH_CARET;
      q_job.body[3]   = in_byte - CTRL_OFS;
      q_job.body_last = 2'd3;
    end else if (show_nonprinting && in_byte >= 8'd160 && in_byte <= 8'd254) begin
      q_job.body[0]   = CH_M;
      q_job.body[1]   = CH_DASH;
      q_job.body[2]   = in_byte - HIGH_OFS;
      q_job.body_last = 2'd2;
    end
  end

  assign q_push   = accept && !squeezed;
  assign q_digits = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev_nl   <= 1'b1;
      blank_run <= 2'd0;
    end else if (accept) begin
      count     <= count_next;
      prev_nl   <= is_nl;
      blank_run <= blank_next;
    end
  end

endmodule

// ----- sv/tlf_queue.sv -----
`timescale 1ns / 1ps

`include "text_line_number_and_escape_filter_macros.svh"

module tlf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tlf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  import tlf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full      = (fill == NW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  `TLF_NEVER(a_push_full, push && full, "item pushed into full queue")
  `TLF_NEVER(a_pop_empty, pop && !not_empty, "pop from empty queue")
  `TLF_ASSERT(a_fill_range, fill <= NW'(DEPTH), "queue fill beyond depth")
  `TLF_ASSERT(a_fill_grow, push && !pop |=> fill == $past(fill) + 1'b1,
              "queue fill did not grow on push")

endmodule

// ----- sv/tlf_back.sv -----
`timescale 1ns / 1ps

`include "text_line_number_and_escape_filter_macros.svh"

module tlf_back #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  tlf_pkg::job_t              q_job,
  input  logic [4*NUMBER_DIGITS-1:0] q_digits,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       last_of_run
);
  import tlf_pkg::*;

  localparam int CW = 4 * NUMBER_DIGITS;
  localparam int IW = ($clog2(NUMBER_DIGITS) > 2) ? $clog2(NUMBER_DIGITS) : 2;

  back_state_t      state;
  back_state_t      state_next;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_next;
  logic             lead;
  logic             lead_next;
  job_t             job;
  logic [CW-1:0]    digits;

  logic             emit;
  logic             emit_last;
  logic [3:0]       digit;
  logic             lead_now;
  logic [7:0]       cur_byte;
  logic             cur_last;

  assign emit      = (state != ST_IDLE) && (!out_valid || !out_stall);
  assign cur_last  = (state == ST_BODY) && (idx[1:0] == job.body_last);
  assign emit_last = emit && cur_last;
  assign q_pop     = q_valid && ((state == ST_IDLE) || emit_last);

  assign digit    = digits[4*idx +: 4];
  // leading zeros print as spaces, the units digit always prints
  assign lead_now = lead && (digit == 4'd0) && (idx != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    lead <= lead_next;
    if (q_pop) begin
      job    <= q_job;
      digits <= q_digits;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    lead_next  = lead;
    cur_byte   = job.body[idx[1:0]];
    unique case (state)
      ST_IDLE: begin
        cur_byte = CH_SPACE;
      end
      ST_DIGIT: begin
        cur_byte = lead_now ? CH_SPACE : CH_ZERO + {4'd0, digit};
        if (emit) begin
          lead_next = lead_now;
          if (idx == '0) state_next = ST_TAB;
          else           idx_next   = idx - 1'b1;
        end
      end
      ST_TAB: begin
        cur_byte = CH_TAB;
        if (emit) begin
          state_next = job.has_dollar ? ST_DOLLAR : ST_BODY;
          idx_next   = '0;
        end
      end
      ST_DOLLAR: begin
        cur_byte = CH_DOLLAR;
        if (emit) begin
          state_next = ST_BODY;
          idx_next   = '0;
        end
      end
      ST_BODY: begin
        if (emit) begin
          if (cur_last) state_next = ST_IDLE;
          else          idx_next   = idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (q_pop) begin
      lead_next = 1'b1;
      if (q_job.has_num) begin
        state_next = ST_DIGIT;
        idx_next   = IW'(NUMBER_DIGITS - 1);
      end else begin
        state_next = q_job.has_dollar ? ST_DOLLAR : ST_BODY;
        idx_next   = '0;
      end
    end
  end

  // output register parts the serialiser from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= cur_byte;
      last_of_run <= cur_last;
    end
  end

  `TLF_ASSERT(a_pop_gap, q_pop |-> (state == ST_IDLE) || emit_last,
              "job taken while previous item still emitting")
  `TLF_ASSERT(a_digit_order, emit && state == ST_DIGIT |=>
              (state == ST_DIGIT) || (state == ST_TAB),
              "number digits not followed by tab")
  `TLF_ASSERT(a_tab_next, emit && state == ST_TAB |=>
              (state == ST_DOLLAR) || (state == ST_BODY),
              "line number tab not followed by item body")
  `TLF_NEVER(a_idle_emit, state == ST_IDLE && emit, "byte emitted with no job")

endmodule

// ----- sv/text_line_number_and_escape_filter.sv -----
`timescale 1ns / 1ps

// Text filter for line numbering, blank-line squeezing and visible control bytes: one
// input byte per item, one output byte per result item, last_of_run marking the final
// byte of an item. The front accepts one item per cycle while its four-entry queue has
// room, updating line count and blank-line state at once; the back emits one byte per
// cycle from an output register while out_stall lets it, and an item makes 1 byte for a
// plain byte, up to NUMBER_DIGITS + 5 for a numbered line start whose first byte takes a
// four-byte M-^ escape, and none for a squeezed blank line.
// Configuration is taken on any cycle (cfg_ready is always high).
module text_line_number_and_escape_filter #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            file_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlf_pkg::*;

  localparam int CW = 4 * NUMBER_DIGITS;
  localparam int QW = $bits(job_t) + CW;

  logic             q_full;
  logic             q_push;
  job_t             push_job;
  logic [CW-1:0]    push_digits;
  logic             q_pop;
  logic             q_not_empty;
  logic [QW-1:0]    pop_data;
  job_t             pop_job;
  logic [CW-1:0]    pop_digits;

  tlf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .file_start (file_start),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job),
    .q_digits   (push_digits)
  );

  tlf_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_job, push_digits}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  assign pop_job    = job_t'(pop_data[QW-1:CW]);
  assign pop_digits = pop_data[CW-1:0];

  tlf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_not_empty),
    .q_job       (pop_job),
    .q_digits    (pop_digits),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ----- verif/tb_text_line_number_and_escape_filter.sv -----
`timescale 1ns / 1ps

module tb_text_line_number_and_escape_filter;
  import tlf_pkg::*;

  localparam int ND           = NUMBER_DIGITS_DEF;
  localparam int MAX_BYTES    = ND + 5;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 13;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_out_t;

  typedef struct packed {
    logic                       is_cfg;
    logic [CFG_INDEX_W-1:0]     reg_sel;
    logic [7:0]                 val;
    logic                       fs;
    logic [2:0]                 n_typed;
    logic [0:3][7:0]            typed;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_byte;
  logic                   file_start;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             out_byte;
  logic                   last_of_run;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor copy of configuration and per-file state
  number_mode_t num_mode;
  logic         sq_blank;
  logic         show_end;
  logic         show_tab;
  logic         show_np;
  logic [3:0]   line_digits [ND];
  logic         prev_nl;
  logic [1:0]   blank_run;

  text_out_t    fmt_buf [MAX_BYTES];
  int           fmt_len;
  text_out_t    pending_text [$];
  stim_row_t    dir_rows [$];

  int           mismatches;
  int           cycle_count;
  int           burst_left;
  int           stall_style;
  int           pattern_left;
  logic         hold_req;
  logic         hold_done;

  text_line_number_and_escape_filter i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .file_start  (file_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_file_state();
    for (int i = 0; i < ND; i++) line_digits[i] = 4'd0;
    prev_nl   = 1'b1;
    blank_run = 2'd0;
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    fmt_buf[fmt_len] = '{ch: c, last: 1'b0};
    fmt_len++;
  endfunction

  // bytes that one input byte turns into, in output order
  function automatic void format_byte(input logic [7:0] b, input logic fs);
    logic all_nine;
    logic carry;
    logic leading;
    fmt_len = 0;
    if (fs) clear_file_state();
    if (b == CH_NL && prev_nl) begin
      if (blank_run < 2'd3) blank_run = blank_run + 2'd1;
    end else begin
      blank_run = 2'd0;
    end
    // squeezed blank line: nothing comes out
    if (sq_blank && blank_run > 2'd1) return;
    if (prev_nl && (num_mode == NUM_ALL || (num_mode == NUM_NONBLANK && b != CH_NL))) begin
      all_nine = 1'b1;
      for (int i = 0; i < ND; i++) begin
        if (line_digits[i] != 4'd9) all_nine = 1'b0;
      end
      // count sticks at all nines
      carry = !all_nine;
      for (int i = ND - 1; i >= 0; i--) begin
        if (carry) begin
          if (line_digits[i] >= 4'd9) begin
            line_digits[i] = 4'd0;
          end else begin
            line_digits[i] = line_digits[i] + 4'd1;
            carry = 1'b0;
          end
        end
      end
      leading = 1'b1;
      for (int i = 0; i < ND; i++) begin
        if (line_digits[i] != 4'd0 || i == ND - 1) leading = 1'b0;
        emit_char(leading ? CH_SPACE : CH_ZERO + {4'd0, line_digits[i]});
      end
      emit_char(CH_TAB);
    end
    if (show_end && b == CH_NL) emit_char(CH_DOLLAR);
    if (show_tab && b == CH_TAB) begin
      emit_char(CH_CARET);
      emit_char(CH_I);
    end else if (show_np && (b <= 8'd8 || (b >= 8'd11 && b <= 8'd31))) begin
      emit_char(CH_CARET);
      emit_char(b + CTRL_OFS);
    end else if (show_np && b == CH_DEL) begin
      emit_char(CH_CARET);
      emit_char(CH_QUEST);
    end else if (show_np && b >= 8'd128 && b <= 8'd159) begin
      emit_char(CH_M);
      emit_char(CH_DASH);
      emit_char(CH_CARET);
      emit_char(b - CTRL_OFS);
    end else if (show_np && b >= 8'd160 && b <= 8'd254) begin
      emit_char(CH_M);
      emit_char(CH_DASH);
      emit_char(b - HIGH_OFS);
    end else begin
      emit_char(b);
    end
    prev_nl = (b == CH_NL);
    fmt_buf[fmt_len-1].last = 1'b1;
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic fs, input int n,
                                   input logic [0:3][7:0] t);
    stim_row_t r;
    r = '0;
    r.val     = b;
    r.fs      = fs;
    r.n_typed = 3'(n);
    r.typed   = t;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = idx;
    r.val     = v;
    dir_rows.push_back(r);
  endfunction

  // mostly text: lines, tabs and newline runs, with some raw bytes mixed in
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return CH_NL;
    if (r < 36) return CH_TAB;
    if (r < 76) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NUMBER_MODE:      num_mode = number_mode_t'(v[1:0]);
      REG_SQUEEZE_BLANK:    sq_blank = v[0];
      REG_SHOW_ENDS:        show_end = v[0];
      REG_SHOW_TABS:        show_tab = v[0];
      REG_SHOW_NONPRINTING: show_np  = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits carry noise, only the low bits count
  task automatic set_all(input number_mode_t m, input logic sq, input logic e,
                         input logic t, input logic np);
    write_reg(REG_NUMBER_MODE, {6'($urandom), m});
    write_reg(REG_SQUEEZE_BLANK, {7'($urandom), sq});
    write_reg(REG_SHOW_ENDS, {7'($urandom), e});
    write_reg(REG_SHOW_TABS, {7'($urandom), t});
    write_reg(REG_SHOW_NONPRINTING, {7'($urandom), np});
  endtask

  task automatic send_item(input logic [7:0] b, input logic fs, input int n_typed,
                           input logic [0:3][7:0] typed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_byte    <= b;
    file_start <= fs;
    do @(posedge clk); while (in_stall);
    format_byte(b, fs);
    if (n_typed == 0) begin
      for (int i = 0; i < fmt_len; i++) pending_text.push_back(fmt_buf[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        pending_text.push_back('{ch: typed[i], last: (i == n_typed - 1)});
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: changing stall styles, plus one long hold-off on request
  initial begin
    pattern_left = 0;
    stall_style  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (pattern_left == 0) begin
        stall_style  = $urandom_range(0, 3);
        pattern_left = $urandom_range(8, 60);
      end
      pattern_left--;
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    text_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_text.size() == 0) begin
        report_mismatch("result with nothing expected", out_byte, 8'h00);
      end else begin
        e = pending_text.pop_front();
        if (out_byte !== e.ch) report_mismatch("out_byte", out_byte, e.ch);
        if (last_of_run !== e.last) report_mismatch("last_of_run", {7'd0, last_of_run},
                                                    {7'd0, e.last});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_line_number_and_escape_filter regression: fail");
      $finish;
    end
  end

  initial begin
    logic drained;
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    file_start  = 1'b0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 0;
    num_mode    = NUM_OFF;
    sq_blank    = 1'b0;
    show_end    = 1'b0;
    show_tab    = 1'b0;
    show_np     = 1'b0;
    clear_file_state();

    // defaults after reset: bytes pass through raw
    add_item(8'h41, 1'b1, 1, {8'h41, 24'h0});
    add_item(8'h00, 1'b0, 1, {8'h00, 24'h0});
    add_item(8'hFF, 1'b0, 1, {8'hFF, 24'h0});
    add_item(CH_NL, 1'b0, 1, {CH_NL, 24'h0});
    add_cfg(REG_SHOW_NONPRINTING, 8'd1);
    add_cfg(REG_SHOW_TABS, 8'd1);
    add_cfg(REG_SHOW_ENDS, 8'd1);
    // every escape class at its edges
    add_item(8'h00, 1'b0, 2, {CH_CARET, 8'h40, 16'h0});
    add_item(8'h1F, 1'b0, 2, {CH_CARET, 8'h5F, 16'h0});
    add_item(CH_DEL, 1'b0, 2, {CH_CARET, CH_QUEST, 16'h0});
    add_item(8'h80, 1'b0, 4, {CH_M, CH_DASH, CH_CARET, 8'h40});
    add_item(8'h9F, 1'b0, 4, {CH_M, CH_DASH, CH_CARET, 8'h5F});
    add_item(8'hA0, 1'b0, 3, {CH_M, CH_DASH, CH_SPACE, 8'h00});
    add_item(8'hFE, 1'b0, 3, {CH_M, CH_DASH, 8'h7E, 8'h00});
    add_item(8'hFF, 1'b0, 1, {8'hFF, 24'h0});
    add_item(CH_TAB, 1'b0, 2, {CH_CARET, CH_I, 16'h0});
    add_item(8'h0B, 1'b0, 2, {CH_CARET, 8'h4B, 16'h0});
    add_item(CH_NL, 1'b0, 2, {CH_DOLLAR, CH_NL, 16'h0});
    // numbered lines with squeezing, blank run past its limit
    add_cfg(REG_NUMBER_MODE, {6'd0, NUM_ALL});
    add_cfg(REG_SQUEEZE_BLANK, 8'd1);
    add_item(8'h78, 1'b1, 0, '0);
    add_item(CH_NL, 1'b0, 0, '0);
    add_item(CH_NL, 1'b0, 0, '0);
    add_item(CH_NL, 1'b0, 0, '0);
    add_item(CH_NL, 1'b0, 0, '0);
    add_item(8'h79, 1'b0, 0, '0);
    // non-blank numbering, escapes off
    add_cfg(REG_NUMBER_MODE, {6'd0, NUM_NONBLANK});
    add_cfg(REG_SHOW_TABS, 8'd0);
    add_cfg(REG_SHOW_NONPRINTING, 8'd0);
    add_cfg(REG_SQUEEZE_BLANK, 8'd0);
    add_cfg(REG_SHOW_ENDS, 8'd0);
    add_item(CH_NL, 1'b1, 0, '0);
    add_item(CH_TAB, 1'b0, 0, '0);
    add_item(8'h01, 1'b0, 0, '0);
    // unused number mode behaves as no numbering
    add_cfg(REG_NUMBER_MODE, {6'd0, NUM_UNUSED});
    add_item(8'h7A, 1'b1, 1, {8'h7A, 24'h0});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    drained = 1'b1;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        if (!drained) wait_idle();
        drained = 1'b1;
        write_reg(dir_rows[r].reg_sel, dir_rows[r].val);
      end else begin
        drained = 1'b0;
        send_item(dir_rows[r].val, dir_rows[r].fs, dir_rows[r].n_typed, dir_rows[r].typed);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: set_all(NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
        1: set_all(NUM_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0);
        2: set_all(NUM_ALL, 1'b1, 1'($urandom), 1'($urandom), 1'($urandom));
        default: set_all(number_mode_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom));
      endcase
      if (ph >= 3) write_reg(CFG_INDEX_W'($urandom_range(5, 7)), 8'($urandom));
      // long receiver hold-off while the sender keeps offering items
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_text.size() != 0) @(posedge clk);
        end
        send_item(text_byte(), ($urandom_range(0, 29) == 0), 0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_text.size() == 0) begin
      $display("text_line_number_and_escape_filter regression: pass");
    end else begin
      $display("text_line_number_and_escape_filter regression: fail");
    end
    $finish;
  end

endmodule
